>>> rtl/fcbp_pkg.sv
// Package for the file-specification parser: types, character codes and parse-step functions.
package fcbp_pkg;

    localparam int NAME_CHARS     = 8;
    localparam int TYPE_CHARS     = 3;
    localparam int PASSWORD_CHARS = 8;

    // FCB slots; the field lengths above may be shorter than these
    localparam int NAME_SLOTS = 8;
    localparam int EXT_SLOTS  = 3;
    localparam int PW_SLOTS   = 8;

    localparam int NAME_BASE  = 1;
    localparam int EXT_BASE   = 9;
    localparam int PW_BASE    = 16;
    localparam logic [5:0] PWLEN_INDEX = 6'd26;
    localparam logic [5:0] LAST_INDEX  = 6'd35;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0d;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_STAR    = 8'h2a;
    localparam logic [7:0] CH_COMMA   = 8'h2c;
    localparam logic [7:0] CH_DOT     = 8'h2e;
    localparam logic [7:0] CH_COLON   = 8'h3a;
    localparam logic [7:0] CH_SEMI    = 8'h3b;
    localparam logic [7:0] CH_LT      = 8'h3c;
    localparam logic [7:0] CH_EQ      = 8'h3d;
    localparam logic [7:0] CH_GT      = 8'h3e;
    localparam logic [7:0] CH_QUEST   = 8'h3f;
    localparam logic [7:0] CH_A       = 8'h41;
    localparam logic [7:0] CH_LBRACK  = 8'h5b;
    localparam logic [7:0] CH_RBRACK  = 8'h5d;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7a;
    localparam logic [7:0] CH_BAR     = 8'h7c;
    localparam logic [7:0] LETTER_MASK = 8'h5f;
    localparam logic [7:0] HIGH_MASK   = 8'h7f;
    localparam int         DRIVE_COUNT = 16;

    localparam logic [15:0] RC_END     = 16'h0000;
    localparam logic [15:0] RC_INVALID = 16'hffff;

    typedef enum logic [7:0] {
        PH_IDLE       = 8'b0000_0001,
        PH_LEAD       = 8'b0000_0010,
        PH_DRIVE      = 8'b0000_0100,
        PH_NAME_FIRST = 8'b0000_1000,
        PH_NAME       = 8'b0001_0000,
        PH_EXT        = 8'b0010_0000,
        PH_PW         = 8'b0100_0000,
        PH_TRAIL      = 8'b1000_0000
    } phase_t;

    typedef enum logic [1:0] {
        TAKE_OK  = 2'd0,
        TAKE_END = 2'd1,
        TAKE_BAD = 2'd2
    } take_code_t;

    typedef logic [7:0][7:0]           field8_t;
    typedef logic [NAME_SLOTS-1:0][7:0] name_t;
    typedef logic [EXT_SLOTS-1:0][7:0]  ext_t;
    typedef logic [PW_SLOTS-1:0][7:0]   pw_t;

    typedef struct packed {
        phase_t      phase;
        logic [7:0]  held;
        logic [4:0]  drive;
        name_t       name;
        ext_t        ext;
        pw_t         pw;
        logic [3:0]  room;
        logic [15:0] stop;
        logic [3:0]  pw_len;
    } parse_t;

    typedef struct packed {
        logic [4:0]  drive;
        name_t       name;
        ext_t        ext;
        pw_t         pw;
        logic [3:0]  pw_len;
        logic [15:0] rc;
    } fcb_rec_t;

    typedef struct packed {
        parse_t      st;
        logic        emit;
        logic [15:0] rc;
    } feed_ret_t;

    typedef struct packed {
        take_code_t code;
        field8_t    field;
        logic [3:0] room;
    } take_ret_t;

    function automatic logic is_delim(logic [7:0] c);
        case (c)
            CH_NUL, CH_CR, CH_TAB, CH_SPACE, CH_DOT, CH_COMMA, CH_COLON,
            CH_SEMI, CH_LBRACK, CH_RBRACK, CH_EQ, CH_LT, CH_GT, CH_BAR: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [7:0] fold(logic [7:0] c);
        if (c < CH_LOWER_A) begin
            return c;
        end else if (c <= CH_LOWER_Z) begin
            return c & LETTER_MASK;
        end else begin
            return c & HIGH_MASK;
        end
    endfunction

    function automatic logic is_blank(logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    // one character into a field; '*' fills the rest with '?' when stars is set
    function automatic take_ret_t take(logic [7:0] c, field8_t field, logic [3:0] room,
                                       logic [3:0] width, logic stars);
        take_ret_t  r;
        logic [7:0] u;
        logic [3:0] pos;
        r.code  = TAKE_OK;
        r.field = field;
        r.room  = room;
        u       = fold(c);
        pos     = width - room;
        if (is_delim(c)) begin
            r.code = TAKE_END;
        end else if (u < CH_SPACE || room == 4'd0 || room > width) begin
            r.code = TAKE_BAD;
        end else if (stars && u == CH_STAR) begin
            for (int i = 0; i < 8; i++) begin
                if (4'(i) >= pos && 4'(i) < width) begin
                    r.field[i] = CH_QUEST;
                end
            end
            r.room = 4'd0;
        end else begin
            for (int i = 0; i < 8; i++) begin
                if (4'(i) == pos) begin
                    r.field[i] = u;
                end
            end
            r.room = room - 4'd1;
        end
        return r;
    endfunction

    // one character through the phases it falls through
    function automatic feed_ret_t feed(parse_t s, logic [7:0] c, logic [15:0] addr);
        feed_ret_t r;
        take_ret_t t;
        logic      done;
        r.st   = s;
        r.emit = 1'b0;
        r.rc   = RC_END;
        done   = 1'b0;
        t      = '0;
        if (r.st.phase == PH_LEAD) begin
            if (is_blank(c)) begin
                done = 1'b1;
            end else if (c == CH_NUL) begin
                r.st.phase = PH_NAME_FIRST;
            end else begin
                r.st.held  = c;
                r.st.phase = PH_DRIVE;
                done       = 1'b1;
            end
        end
        if (!done && r.st.phase == PH_NAME_FIRST) begin
            if (is_delim(c)) begin
                r.st.stop  = addr;
                r.st.phase = PH_TRAIL;
            end else begin
                r.st.room  = 4'(NAME_CHARS);
                r.st.phase = PH_NAME;
            end
        end
        if (!done && r.st.phase == PH_NAME) begin
            if (c == CH_DOT) begin
                r.st.phase = PH_EXT;
                r.st.room  = 4'(TYPE_CHARS);
                done       = 1'b1;
            end else if (c == CH_SEMI) begin
                r.st.phase = PH_PW;
                r.st.room  = 4'(PASSWORD_CHARS);
                done       = 1'b1;
            end else begin
                t = take(c, field8_t'(r.st.name), r.st.room, 4'(NAME_CHARS), 1'b1);
                r.st.name = t.field[NAME_SLOTS-1:0];
                r.st.room = t.room;
                case (t.code)
                    TAKE_OK: begin
                        done = 1'b1;
                    end
                    TAKE_BAD: begin
                        r.emit = 1'b1;
                        r.rc   = RC_INVALID;
                        done   = 1'b1;
                    end
                    default: begin
                        r.st.stop  = addr;
                        r.st.phase = PH_TRAIL;
                    end
                endcase
            end
        end
        if (!done && r.st.phase == PH_EXT) begin
            if (c == CH_SEMI) begin
                r.st.phase = PH_PW;
                r.st.room  = 4'(PASSWORD_CHARS);
                done       = 1'b1;
            end else begin
                t = take(c, {{(8 - EXT_SLOTS){CH_SPACE}}, r.st.ext}, r.st.room,
                         4'(TYPE_CHARS), 1'b1);
                r.st.ext  = t.field[EXT_SLOTS-1:0];
                r.st.room = t.room;
                case (t.code)
                    TAKE_OK: begin
                        done = 1'b1;
                    end
                    TAKE_BAD: begin
                        r.emit = 1'b1;
                        r.rc   = RC_INVALID;
                        done   = 1'b1;
                    end
                    default: begin
                        r.st.stop  = addr;
                        r.st.phase = PH_TRAIL;
                    end
                endcase
            end
        end
        if (!done && r.st.phase == PH_PW) begin
            t = take(c, field8_t'(r.st.pw), r.st.room, 4'(PASSWORD_CHARS), 1'b0);
            r.st.pw   = t.field[PW_SLOTS-1:0];
            r.st.room = t.room;
            if (t.code != TAKE_OK) begin
                r.st.pw_len = 4'(PASSWORD_CHARS) - t.room;
            end
            case (t.code)
                TAKE_OK: begin
                    done = 1'b1;
                end
                TAKE_BAD: begin
                    r.emit = 1'b1;
                    r.rc   = RC_INVALID;
                    done   = 1'b1;
                end
                default: begin
                    r.st.stop  = addr;
                    r.st.phase = PH_TRAIL;
                end
            endcase
        end
        if (!done && r.st.phase == PH_TRAIL) begin
            if (!is_blank(c)) begin
                r.emit = 1'b1;
                if (is_delim(c)) begin
                    r.rc = (c == CH_NUL || c == CH_CR) ? RC_END : addr;
                end else begin
                    r.rc = r.st.stop;
                end
            end
        end
        if (r.emit) begin
            r.st.phase = PH_IDLE;
        end
        return r;
    endfunction

    // whole step for one accepted character; cur already reflects a restart
    function automatic feed_ret_t step(parse_t cur, logic [7:0] c, logic [15:0] cursor);
        feed_ret_t  r;
        feed_ret_t  f1;
        parse_t     s;
        logic [7:0] u;
        logic [15:0] prev;
        prev = cursor - 16'd1;
        s    = cur;
        u    = fold(cur.held);
        f1   = '0;
        if (cur.phase == PH_DRIVE) begin
            if (c == CH_COLON) begin
                if (is_delim(cur.held)) begin
                    s.stop  = prev;
                    s.phase = PH_TRAIL;
                    r = feed(s, cur.held, prev);
                end else if (u < CH_A || u > CH_A + 8'(DRIVE_COUNT - 1)) begin
                    s.phase = PH_IDLE;
                    r.st    = s;
                    r.emit  = 1'b1;
                    r.rc    = RC_INVALID;
                end else begin
                    s.drive = 5'(u - CH_A + 8'd1);
                    s.phase = PH_NAME_FIRST;
                    r.st    = s;
                    r.emit  = 1'b0;
                    r.rc    = RC_END;
                end
            end else begin
                // held character goes first, then this one
                s.phase = PH_NAME_FIRST;
                f1 = feed(s, cur.held, prev);
                if (f1.emit) begin
                    r = f1;
                end else begin
                    r = feed(f1.st, c, cursor);
                end
            end
        end else begin
            r = feed(cur, c, cursor);
        end
        return r;
    endfunction

    function automatic logic [7:0] fcb_byte_at(fcb_rec_t rec, logic [5:0] idx);
        logic [7:0] b;
        b = 8'h00;
        if (idx == 6'd0) begin
            b = {3'b000, rec.drive};
        end
        for (int i = 0; i < NAME_SLOTS; i++) begin
            if (idx == 6'(NAME_BASE + i)) b = rec.name[i];
        end
        for (int i = 0; i < EXT_SLOTS; i++) begin
            if (idx == 6'(EXT_BASE + i)) b = rec.ext[i];
        end
        for (int i = 0; i < PW_SLOTS; i++) begin
            if (idx == 6'(PW_BASE + i)) b = rec.pw[i];
        end
        if (idx == PWLEN_INDEX) begin
            b = {4'b0000, rec.pw_len};
        end
        return b;
    endfunction

endpackage

>>> rtl/filename_to_fcb_parser.sv
// File-specification parser: character stream in, 36-byte file control block out.
//
//  channel  dir  payload                                              framing
//  s_       in   tdata: char_in[7:0], base_address[23:8]; tuser: start_req
//  m_       out  tdata: byte_index[5:0], fcb_byte[13:6], return_code[29:14]
//                                                                     tlast on byte 35
//
// One character is taken per cycle while s_tready is high; its parse step finishes in that cycle.
// A character that ends the parse queues a 36-beat FCB burst (one byte per beat).
// One finished FCB can wait behind the one in flight; s_tready drops only when both
// slots are full, and a stalled m_tready holds the current beat.
// aresetn (synchronous) returns the parser to idle and empties both FCB slots.
module filename_to_fcb_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // char_in[7:0], base_address[23:8]
    input  logic        s_tuser,   // start_req
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // byte_index[5:0], fcb_byte[13:6], return_code[29:14]
    output logic        m_tlast
);

    fcbp_pkg::parse_t    state_reg;
    logic [15:0]         cursor_reg;
    fcbp_pkg::parse_t    cur;
    logic [15:0]         cursor;
    fcbp_pkg::feed_ret_t step_ret;
    fcbp_pkg::fcb_rec_t  new_rec;

    fcbp_pkg::fcb_rec_t  out_rec_reg;
    logic [5:0]          out_idx_reg;
    logic                out_valid_reg;
    fcbp_pkg::fcb_rec_t  pend_rec_reg;
    logic                pend_valid_reg;

    logic                in_acc;
    logic                out_acc;
    logic                out_done;
    logic [7:0]          out_byte;
    logic [15:0]         out_rc;

    always_comb begin
        cur    = state_reg;
        cursor = cursor_reg;
        if (s_tuser) begin
            cur.phase  = fcbp_pkg::PH_LEAD;
            cur.held   = 8'h00;
            cur.drive  = 5'd0;
            cur.name   = {fcbp_pkg::NAME_SLOTS{fcbp_pkg::CH_SPACE}};
            cur.ext    = {fcbp_pkg::EXT_SLOTS{fcbp_pkg::CH_SPACE}};
            cur.pw     = {fcbp_pkg::PW_SLOTS{fcbp_pkg::CH_SPACE}};
            cur.room   = 4'd0;
            cur.stop   = 16'd0;
            cur.pw_len = 4'd0;
            cursor     = s_tdata[23:8];
        end
        step_ret = fcbp_pkg::step(cur, s_tdata[7:0], cursor);
    end

    always_comb begin
        new_rec.drive  = step_ret.st.drive;
        new_rec.name   = step_ret.st.name;
        new_rec.ext    = step_ret.st.ext;
        new_rec.pw     = step_ret.st.pw;
        new_rec.pw_len = step_ret.st.pw_len;
        new_rec.rc     = step_ret.rc;
    end

    assign s_tready = !pend_valid_reg;
    assign in_acc   = s_tvalid && s_tready;
    assign out_acc  = out_valid_reg && m_tready;
    assign out_done = out_acc && (out_idx_reg == fcbp_pkg::LAST_INDEX);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase <= fcbp_pkg::PH_IDLE;
            cursor_reg      <= 16'd0;
            out_valid_reg   <= 1'b0;
            out_idx_reg     <= 6'd0;
            pend_valid_reg  <= 1'b0;
        end else begin
            if (in_acc) begin
                state_reg  <= step_ret.st;
                cursor_reg <= cursor + 16'd1;
            end
            if (out_acc) begin
                if (out_idx_reg == fcbp_pkg::LAST_INDEX) begin
                    if (pend_valid_reg) begin
                        out_rec_reg    <= pend_rec_reg;
                        out_idx_reg    <= 6'd0;
                        pend_valid_reg <= 1'b0;
                    end else if (!(in_acc && step_ret.emit)) begin
                        // a new FCB loading this cycle keeps the slot busy
                        out_valid_reg <= 1'b0;
                    end
                end else begin
                    out_idx_reg <= out_idx_reg + 6'd1;
                end
            end
            if (in_acc && step_ret.emit) begin
                // slot frees this cycle only when the last beat leaves and nothing waits
                if (!out_valid_reg || (out_done && !pend_valid_reg)) begin
                    out_rec_reg   <= new_rec;
                    out_idx_reg   <= 6'd0;
                    out_valid_reg <= 1'b1;
                end else begin
                    pend_rec_reg   <= new_rec;
                    pend_valid_reg <= 1'b1;
                end
            end
        end
    end

    assign out_byte = fcbp_pkg::fcb_byte_at(out_rec_reg, out_idx_reg);
    assign out_rc   = (out_idx_reg == fcbp_pkg::LAST_INDEX) ? out_rec_reg.rc : 16'd0;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_rc, out_byte, out_idx_reg};
    assign m_tlast  = (out_idx_reg == fcbp_pkg::LAST_INDEX);

endmodule
